// ===== rtl/core/bb3_pkg.sv =====
// shared types, register indexes and reciprocal table for the box blur
`default_nettype none
package bb3_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_t;

    // window[k][s]: k column (0 = two columns back), s row (0 = two rows up)
    typedef pix_t [2:0][2:0] window_t;

    typedef struct packed {
        window_t     win;
        logic [15:0] row;
        logic [9:0]  col;
        logic        r_ge1;
        logic        r_ge2;
        logic        c_ge1;
        logic        c_ge2;
        logic [3:0]  emits;
    } job_t;

    typedef enum logic {
        F_IDLE,
        F_PROC
    } front_state_t;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    localparam int RCP_SHIFT = 20;

    // ceil(2^20 / (2*cnt)); exact quotient for numerators below 8192
    function automatic logic [19:0] recip(input logic [3:0] cnt);
        logic [19:0] r;
        case (cnt)
            4'd1: r = 20'd524288;
            4'd2: r = 20'd262144;
            4'd3: r = 20'd174763;
            4'd4: r = 20'd131072;
            4'd5: r = 20'd104858;
            4'd6: r = 20'd87382;
            4'd7: r = 20'd74899;
            4'd8: r = 20'd65536;
            4'd9: r = 20'd58255;
            default: r = 20'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bb3_ram.sv =====
// generic simple dual port ram with registered read
`default_nettype none
module bb3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/bb3_front.sv =====
// front end: line buffers, window and classification of each pixel
`default_nettype none
module bb3_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire  [10:0]       image_width,
    input  wire  [15:0]       image_height,
    input  wire               push,
    output logic              full,
    input  wire  [7:0]        in_red,
    input  wire  [7:0]        in_green,
    input  wire  [7:0]        in_blue,
    input  wire               q_full,
    output logic              q_push,
    output bb3_pkg::job_t     q_job
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WW    = COL_W + 1;

    bb3_pkg::front_state_t state_reg, state_next;

    logic [15:0]      input_row_reg;
    logic [COL_W-1:0] input_column_reg;
    logic [15:0]      r_reg;
    logic [COL_W-1:0] c_reg;
    logic             c_last_reg, r_last_reg;
    bb3_pkg::pix_t    pix_reg;
    bb3_pkg::window_t win_reg, win_next;

    logic [WW-1:0]    w_eff;
    logic [COL_W-1:0] w_last, c_eff;
    logic [15:0]      h_eff, h_last, r_eff;
    logic             accept;

    bb3_pkg::pix_t older_rd, newer_rd;

    // effective frame size and clamped position
    always_comb
    begin
        if (image_width == 11'd0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(image_width) > 32'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(image_width);
        end
        w_last = COL_W'(w_eff - WW'(1));
        c_eff  = (input_column_reg > w_last) ? w_last : input_column_reg;
        h_eff  = (image_height == 16'd0) ? 16'd1 : image_height;
        h_last = h_eff - 16'd1;
        r_eff  = (input_row_reg > h_last) ? h_last : input_row_reg;
    end

    assign accept = push && !full;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bb3_pkg::F_IDLE: if (accept) state_next = bb3_pkg::F_PROC;
            bb3_pkg::F_PROC: state_next = bb3_pkg::F_IDLE;
            default:         state_next = bb3_pkg::F_IDLE;
        endcase
    end

    always_comb
    begin
        full   = 1'b1;
        q_push = 1'b0;
        case (state_reg)
            bb3_pkg::F_IDLE:
            begin
                full = q_full;
            end
            bb3_pkg::F_PROC:
            begin
                q_push = 1'b1;
            end
            default:
            begin
                full = 1'b1;
            end
        endcase
    end

    bb3_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_older (
        .clk   (clk),
        .we    (q_push),
        .waddr (c_reg),
        .wdata (newer_rd),
        .raddr (c_eff),
        .rdata (older_rd)
    );

    bb3_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_newer (
        .clk   (clk),
        .we    (q_push),
        .waddr (c_reg),
        .wdata (pix_reg),
        .raddr (c_eff),
        .rdata (newer_rd)
    );

    always_comb
    begin
        win_next       = win_reg;
        win_next[0]    = win_reg[1];
        win_next[1]    = win_reg[2];
        win_next[2][0] = older_rd;
        win_next[2][1] = newer_rd;
        win_next[2][2] = pix_reg;
    end

    always_comb
    begin
        q_job.win   = win_next;
        q_job.row   = r_reg;
        q_job.col   = 10'(c_reg);
        q_job.r_ge1 = (r_reg != 16'd0);
        q_job.r_ge2 = (r_reg > 16'd1);
        q_job.c_ge1 = (c_reg != '0);
        q_job.c_ge2 = (c_reg > COL_W'(1));
        q_job.emits[0] = q_job.r_ge1 && q_job.c_ge1;
        q_job.emits[1] = q_job.r_ge1 && c_last_reg;
        q_job.emits[2] = r_last_reg && q_job.c_ge1;
        q_job.emits[3] = r_last_reg && c_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bb3_pkg::F_IDLE;
            input_row_reg    <= '0;
            input_column_reg <= '0;
            win_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_push)
            begin
                win_reg <= win_next;
                if (c_last_reg)
                begin
                    input_column_reg <= '0;
                    input_row_reg    <= r_last_reg ? 16'd0 : r_reg + 16'd1;
                end
                else
                begin
                    input_column_reg <= c_reg + COL_W'(1);
                    input_row_reg    <= r_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            r_reg      <= r_eff;
            c_reg      <= c_eff;
            c_last_reg <= (c_eff == w_last);
            r_last_reg <= (r_eff == h_last);
            pix_reg    <= '{red: in_red, green: in_green, blue: in_blue};
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/bb3_queue.sv =====
// short job queue between front and back end
`default_nettype none
module bb3_queue (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            push,
    input  bb3_pkg::job_t  push_job,
    input  wire            pop,
    output logic           full,
    output logic           valid,
    output bb3_pkg::job_t  head
);

    bb3_pkg::job_t                mem_reg [bb3_pkg::QDEPTH];
    logic [bb3_pkg::QPTR_W-1:0]   wptr_reg, rptr_reg;
    logic [bb3_pkg::QPTR_W:0]     count_reg;

    assign full  = (count_reg == (bb3_pkg::QPTR_W+1)'(bb3_pkg::QDEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/bb3_back.sv =====
// back end: per-result window sum, reciprocal divide and output register
`default_nettype none
module bb3_back (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            q_valid,
    input  bb3_pkg::job_t  q_head,
    output logic           q_pop,
    output logic           empty,
    input  wire            pop,
    output logic [7:0]     out_red,
    output logic [7:0]     out_green,
    output logic [7:0]     out_blue,
    output logic [15:0]    out_row,
    output logic [9:0]     out_column,
    output logic           last_in_run,
    output logic           last_of_frame
);

    logic [3:0] done_reg, pend, pick, rest;
    logic       advance, issue, row_prev, col_prev;
    logic [2:0] rowm, colm;
    logic [11:0] sum_r, sum_g, sum_b;
    logic [3:0]  cnt;

    logic        v1_reg, vout_reg;
    logic [12:0] n_r_reg, n_g_reg, n_b_reg;
    logic [19:0] rcp_reg;
    logic [15:0] row1_reg;
    logic [9:0]  col1_reg;
    logic        lir1_reg, lof1_reg;
    logic [32:0] p_r, p_g, p_b;

    assign pend    = q_head.emits & ~done_reg;
    assign advance = !vout_reg || pop;
    assign empty   = !vout_reg;

    // lowest pending result first keeps raster order
    always_comb
    begin
        if (pend[0])      pick = 4'b0001;
        else if (pend[1]) pick = 4'b0010;
        else if (pend[2]) pick = 4'b0100;
        else              pick = 4'b1000;
    end

    assign rest  = pend & ~pick;
    assign issue = advance && q_valid && (pend != 4'd0);
    assign q_pop = q_valid && ((pend == 4'd0) || (issue && (rest == 4'd0)));

    assign row_prev = pick[0] || pick[1];
    assign col_prev = pick[0] || pick[2];
    assign rowm = {1'b1, q_head.r_ge1, row_prev && q_head.r_ge2};
    assign colm = {1'b1, q_head.c_ge1, col_prev && q_head.c_ge2};

    always_comb
    begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        cnt   = '0;
        for (int k = 0; k < 3; k++)
        begin
            for (int s = 0; s < 3; s++)
            begin
                if (rowm[s] && colm[k])
                begin
                    sum_r = sum_r + 12'(q_head.win[k][s].red);
                    sum_g = sum_g + 12'(q_head.win[k][s].green);
                    sum_b = sum_b + 12'(q_head.win[k][s].blue);
                    cnt   = cnt + 4'd1;
                end
            end
        end
    end

    assign p_r = 33'(n_r_reg) * 33'(rcp_reg);
    assign p_g = 33'(n_g_reg) * 33'(rcp_reg);
    assign p_b = 33'(n_b_reg) * 33'(rcp_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= '0;
            v1_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                done_reg <= '0;
            end
            else if (issue)
            begin
                done_reg <= done_reg | pick;
            end
            if (advance)
            begin
                v1_reg   <= issue;
                vout_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            n_r_reg  <= 13'({sum_r, 1'b0}) + 13'(cnt);
            n_g_reg  <= 13'({sum_g, 1'b0}) + 13'(cnt);
            n_b_reg  <= 13'({sum_b, 1'b0}) + 13'(cnt);
            rcp_reg  <= bb3_pkg::recip(cnt);
            row1_reg <= q_head.row - (row_prev ? 16'd1 : 16'd0);
            col1_reg <= q_head.col - (col_prev ? 10'd1 : 10'd0);
            lir1_reg <= (rest == 4'd0);
            lof1_reg <= pick[3];

            out_red       <= p_r[bb3_pkg::RCP_SHIFT +: 8];
            out_green     <= p_g[bb3_pkg::RCP_SHIFT +: 8];
            out_blue      <= p_b[bb3_pkg::RCP_SHIFT +: 8];
            out_row       <= row1_reg;
            out_column    <= col1_reg;
            last_in_run   <= lir1_reg;
            last_of_frame <= lof1_reg;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/box_blur_3x3_rgb.sv =====
// top level of the streaming 3x3 rgb box blur
`default_nettype none
// Streaming 3x3 box blur over RGB pixels in raster order. Each result is the
// rounded-half-up mean of the in-frame neighbours of a pixel and appears once
// its last neighbour has arrived, so a pixel releases zero to four results,
// tagged last_in_run and last_of_frame. Line buffer rams are read in the accept
// cycle and written back in the next, with no pixel taken between. A two-entry
// job queue feeds the back end, which produces one result per cycle while the
// output is not held, through a sum stage and a reciprocal multiply stage. The
// user sets frame size over the APB port (width at 0x0, height at 0x4) only
// while idle, unchecked by the block. No clearing pass is needed after reset.
module box_blur_3x3_rgb #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         push,
    output logic        full,
    input  wire  [7:0]  in_red,
    input  wire  [7:0]  in_green,
    input  wire  [7:0]  in_blue,
    output logic        empty,
    input  wire         pop,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [15:0] out_row,
    output logic [9:0]  out_column,
    output logic        last_in_run,
    output logic        last_of_frame
);

    logic [10:0] image_width_reg;
    logic [15:0] image_height_reg;
    logic        cfg_wr;

    logic          q_full, q_push, q_pop, q_valid;
    bb3_pkg::job_t q_job, q_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == bb3_pkg::REG_HEIGHT) ? {16'd0, image_height_reg}
                                                       : {21'd0, image_width_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= 11'd1024;
            image_height_reg <= 16'd768;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == bb3_pkg::REG_WIDTH)
            begin
                image_width_reg <= pwdata[10:0];
            end
            else
            begin
                image_height_reg <= pwdata[15:0];
            end
        end
    end

    bb3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .push         (push),
        .full         (full),
        .in_red       (in_red),
        .in_green     (in_green),
        .in_blue      (in_blue),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (q_job)
    );

    bb3_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .full     (q_full),
        .valid    (q_valid),
        .head     (q_head)
    );

    bb3_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .out_red       (out_red),
        .out_green     (out_green),
        .out_blue      (out_blue),
        .out_row       (out_row),
        .out_column    (out_column),
        .last_in_run   (last_in_run),
        .last_of_frame (last_of_frame)
    );

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// testbench for the streaming 3x3 rgb box blur: random frames against a local blur predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

    localparam int LINE_MAX = 1024;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_beat_t;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] row;
        logic [9:0]  column;
        logic        run_end;
        logic        frame_end;
    } blur_beat_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        push;
    logic        full;
    logic [7:0]  in_red;
    logic [7:0]  in_green;
    logic [7:0]  in_blue;
    logic        empty;
    logic        pop;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [15:0] out_row;
    logic [9:0]  out_column;
    logic        last_in_run;
    logic        last_of_frame;

    box_blur_3x3_rgb dut (.*);

    // predictor state
    pixel_beat_t older_q [LINE_MAX];
    pixel_beat_t newer_q [LINE_MAX];
    pixel_beat_t win_q [3][3];
    int unsigned cur_row;
    int unsigned cur_col;
    int unsigned frame_w;
    int unsigned frame_h;

    pixel_beat_t pixel_queue[$];
    blur_beat_t  blur_expected[$];
    int          mismatch_count;
    int          accepted_count;
    bit          idle_enable;

    initial
    begin
        clk = 1'b0;
    end
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic blur_beat_t blur_pixel(int r, int c, int rr, int cc, int w, int h);
        blur_beat_t b;
        int unsigned sr;
        int unsigned sg;
        int unsigned sb;
        int unsigned n;
        int col;
        int row;
        sr = 0;
        sg = 0;
        sb = 0;
        n = 0;
        for (int k = 0; k < 3; k++)
        begin
            col = c - 2 + k;
            if (col < 0 || col < cc - 1 || col > cc + 1 || col >= w)
                continue;
            for (int s = 0; s < 3; s++)
            begin
                row = r - 2 + s;
                if (row < 0 || row < rr - 1 || row > rr + 1 || row >= h)
                    continue;
                sr += win_q[k][s].red;
                sg += win_q[k][s].green;
                sb += win_q[k][s].blue;
                n++;
            end
        end
        b.red = (n != 0) ? 8'((2 * sr + n) / (2 * n)) : 8'd0;
        b.green = (n != 0) ? 8'((2 * sg + n) / (2 * n)) : 8'd0;
        b.blue = (n != 0) ? 8'((2 * sb + n) / (2 * n)) : 8'd0;
        b.row = 16'(rr);
        b.column = 10'(cc);
        b.run_end = 1'b0;
        b.frame_end = (rr == h - 1 && cc == w - 1);
        return b;
    endfunction

    task automatic blur_accept(pixel_beat_t p);
        int w;
        int h;
        int r;
        int c;
        blur_beat_t run_q[$];
        w = frame_w;
        h = frame_h;
        if (w < 1)
            w = 1;
        if (w > LINE_MAX)
            w = LINE_MAX;
        if (h < 1)
            h = 1;
        r = cur_row;
        c = cur_col;
        if (r > h - 1)
            r = h - 1;
        if (c > w - 1)
            c = w - 1;
        for (int s = 0; s < 3; s++)
        begin
            win_q[0][s] = win_q[1][s];
            win_q[1][s] = win_q[2][s];
        end
        win_q[2][0] = older_q[c];
        win_q[2][1] = newer_q[c];
        win_q[2][2] = p;
        older_q[c] = newer_q[c];
        newer_q[c] = p;
        if (r >= 1)
        begin
            if (c >= 1)
                run_q.push_back(blur_pixel(r, c, r - 1, c - 1, w, h));
            if (c == w - 1)
                run_q.push_back(blur_pixel(r, c, r - 1, c, w, h));
        end
        if (r == h - 1)
        begin
            if (c >= 1)
                run_q.push_back(blur_pixel(r, c, r, c - 1, w, h));
            if (c == w - 1)
                run_q.push_back(blur_pixel(r, c, r, c, w, h));
        end
        if (run_q.size() > 0)
            run_q[run_q.size() - 1].run_end = 1'b1;
        foreach (run_q[i])
            blur_expected.push_back(run_q[i]);
        if (c == w - 1)
        begin
            cur_col = 0;
            cur_row = (r == h - 1) ? 0 : r + 1;
        end
        else
        begin
            cur_col = c + 1;
            cur_row = r;
        end
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_queue.size() > 0 && (!idle_enable || $urandom_range(99) >= 38))
            begin
                push <= 1'b1;
                in_red <= pixel_queue[0].red;
                in_green <= pixel_queue[0].green;
                in_blue <= pixel_queue[0].blue;
            end
            else
                push <= 1'b0;
            pop <= !idle_enable || $urandom_range(99) >= 38;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        blur_beat_t got;
        blur_beat_t want;
        if (rst_n)
        begin
            if (push && !full)
            begin
                void'(pixel_queue.pop_front());
                blur_accept('{red: in_red, green: in_green, blue: in_blue});
                accepted_count++;
            end
            if (pop && !empty)
            begin
                got = '{out_red, out_green, out_blue, out_row, out_column,
                        last_in_run, last_of_frame};
                if (blur_expected.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected beat %p", got);
                end
                else
                begin
                    want = blur_expected.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
        end
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == 3'(4 * bb3_pkg::REG_WIDTH))
            frame_w = value[10:0];
        else
            frame_h = value[15:0];
    endtask

    task automatic drain_wait();
        wait (pixel_queue.size() == 0 && !push);
        wait (blur_expected.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    function automatic pixel_beat_t random_pixel();
        pixel_beat_t p;
        p = 24'($urandom);
        return p;
    endfunction

    // whole frames (or a part of one) of pixels
    task automatic frame_fill(int n, int style);
        pixel_beat_t p;
        for (int i = 0; i < n; i++)
        begin
            case (style)
                0: p = random_pixel();
                1: p = (i % 2) ? 24'hffffff : 24'h000000;
                default: p = ($urandom_range(1)) ? 24'hffffff : random_pixel();
            endcase
            pixel_queue.push_back(p);
        end
    endtask

    task automatic frame_run(int w, int h, int frames, int style);
        reg_write(3'(4 * bb3_pkg::REG_WIDTH), 32'(w));
        reg_write(3'(4 * bb3_pkg::REG_HEIGHT), 32'(h));
        frame_fill(w * h * frames, style);
        drain_wait();
    endtask

    initial
    begin
        int w;
        int h;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        push = 1'b0;
        pop = 1'b0;
        in_red = '0;
        in_green = '0;
        in_blue = '0;
        mismatch_count = 0;
        accepted_count = 0;
        idle_enable = 1'b1;
        cur_row = 0;
        cur_col = 0;
        frame_w = 1024;
        frame_h = 768;
        for (int i = 0; i < LINE_MAX; i++)
        begin
            older_q[i] = '0;
            newer_q[i] = '0;
        end
        for (int k = 0; k < 3; k++)
            for (int s = 0; s < 3; s++)
                win_q[k][s] = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: degenerate sizes and extreme values
        frame_run(1, 1, 3, 1);
        frame_run(1, 4, 1, 1);
        frame_run(4, 1, 1, 1);
        frame_run(3, 3, 1, 1);
        frame_run(2, 2, 1, 2);
        // zero sizes act as one
        frame_run(0, 0, 2, 0);
        // height at its register extreme with just two rows fed
        reg_write(3'(4 * bb3_pkg::REG_WIDTH), 32'd2);
        reg_write(3'(4 * bb3_pkg::REG_HEIGHT), 32'd65535);
        frame_fill(4, 0);
        drain_wait();
        // shrink mid-frame, current row lands beyond the last
        reg_write(3'(4 * bb3_pkg::REG_HEIGHT), 32'd1);
        frame_fill(2, 0);
        drain_wait();
        // width above the line length clamps, part of a row fed
        reg_write(3'(4 * bb3_pkg::REG_WIDTH), 32'd2047);
        reg_write(3'(4 * bb3_pkg::REG_HEIGHT), 32'd2);
        frame_fill(8, 0);
        drain_wait();

        // random frames, a stretch with no idling in the middle
        while (accepted_count < 420)
        begin
            idle_enable = !(accepted_count > 150 && accepted_count < 300);
            w = ($urandom_range(4) == 0) ? $urandom_range(24, 13) : $urandom_range(12, 1);
            h = $urandom_range(6, 1);
            frame_run(w, h, 1, $urandom_range(2));
        end
        idle_enable = 1'b1;
        drain_wait();
        if (mismatch_count == 0 && blur_expected.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/bb3_pkg.sv
rtl/core/bb3_ram.sv
rtl/core/bb3_front.sv
rtl/core/bb3_queue.sv
rtl/core/bb3_back.sv
rtl/core/box_blur_3x3_rgb.sv
sim/tb_top.sv
